@@ rtl/midpoint_subdivision_line_clipper_assert.svh @@
// ----------------------------------------------------------------------------
// midpoint subdivision line clipper assertion macros
// concurrent assertion wrappers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_SUBDIVISION_LINE_CLIPPER_ASSERT_SVH
`define MIDPOINT_SUBDIVISION_LINE_CLIPPER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MSLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MSLC_ASSERT_SAME(label, ante, cons, msg)
`define MSLC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/mslc_pkg.sv @@
// ----------------------------------------------------------------------------
// mslc_pkg
// shared types, constants and the region coding function of the line clipper
// ----------------------------------------------------------------------------
package mslc_pkg;

    localparam int COORD_BITS   = 16;
    localparam int SEARCH_LIMIT = 2 * COORD_BITS + 4;
    localparam int ITER_BITS    = $clog2(SEARCH_LIMIT + 1);
    localparam int CFG_IDX_BITS = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [3:0]                   code_t;
    typedef logic [ITER_BITS-1:0]         iter_t;
    typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

    // region code bits
    localparam code_t CODE_LEFT  = 4'b0001;
    localparam code_t CODE_RIGHT = 4'b0010;
    localparam code_t CODE_BELOW = 4'b0100;
    localparam code_t CODE_ABOVE = 4'b1000;
    localparam code_t CODE_INSIDE = 4'b0000;

    // configuration register indexes
    localparam cfg_idx_t CFG_WIN_XMIN = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_WIN_XMAX = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_WIN_YMIN = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_WIN_YMAX = cfg_idx_t'(3);

    // window reset values
    localparam coord_t WIN_XMIN_RST = coord_t'(0);
    localparam coord_t WIN_XMAX_RST = coord_t'(4095);
    localparam coord_t WIN_YMIN_RST = coord_t'(0);
    localparam coord_t WIN_YMAX_RST = coord_t'(4095);

    typedef struct packed {
        coord_t xmin;
        coord_t xmax;
        coord_t ymin;
        coord_t ymax;
    } window_t;

    // operands of one halving step
    typedef struct packed {
        coord_t lo_x;
        coord_t lo_y;
        coord_t hi_x;
        coord_t hi_y;
        code_t  lo_code;
        code_t  hi_code;
        logic   toward_end;
        iter_t  iter;
    } step_in_t;

    // outcome of one halving step
    typedef struct packed {
        coord_t mid_x;
        coord_t mid_y;
        code_t  mid_code;
        logic   stop;
        logic   move_hi;
        coord_t res_x;
        coord_t res_y;
        code_t  res_code;
    } step_out_t;

    // four-bit outcode, left over right and above over below
    function automatic code_t region_code(coord_t x, coord_t y, window_t w);
        code_t c;
        c = CODE_INSIDE;
        if (y < w.ymin)
            c = CODE_ABOVE;
        else if (y > w.ymax)
            c = CODE_BELOW;
        if (x < w.xmin)
            c = c | CODE_LEFT;
        else if (x > w.xmax)
            c = c | CODE_RIGHT;
        return c;
    endfunction

endpackage

@@ rtl/mslc_ifs.sv @@
// ----------------------------------------------------------------------------
// mslc channel interfaces
// valid/ready channels for segments, clip results and register writes
// ----------------------------------------------------------------------------
interface mslc_seg_if
    import mslc_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

interface mslc_clip_if
    import mslc_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;

    modport source (output valid, output visible, output clip_start_x,
                    output clip_start_y, output clip_end_x, output clip_end_y,
                    input ready);
    modport sink   (input valid, input visible, input clip_start_x,
                    input clip_start_y, input clip_end_x, input clip_end_y,
                    output ready);
endinterface

interface mslc_cfg_if
    import mslc_pkg::*;
();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    coord_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mslc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mslc_cfg_regs
// clip window register file, written one register per transaction
// ----------------------------------------------------------------------------
module mslc_cfg_regs
    import mslc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    mslc_cfg_if.sink cfg,
    output window_t win
);

    window_t win_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign win       = win_reg;

    // register update, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.xmin <= WIN_XMIN_RST;
            win_reg.xmax <= WIN_XMAX_RST;
            win_reg.ymin <= WIN_YMIN_RST;
            win_reg.ymax <= WIN_YMAX_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WIN_XMIN: win_reg.xmin <= cfg.data;
                CFG_WIN_XMAX: win_reg.xmax <= cfg.data;
                CFG_WIN_YMIN: win_reg.ymin <= cfg.data;
                CFG_WIN_YMAX: win_reg.ymax <= cfg.data;
                default:      ;
            endcase
        end
    end

endmodule

@@ rtl/mslc_step_unit.sv @@
// ----------------------------------------------------------------------------
// mslc_step_unit
// shared halving step: midpoint, its outcode, stop test, final point and interval choice
// ----------------------------------------------------------------------------
module mslc_step_unit
    import mslc_pkg::*;
(
    input  window_t   win,
    input  step_in_t  op,
    output step_out_t res
);

    logic signed [COORD_BITS:0] sum_x;
    logic signed [COORD_BITS:0] sum_y;
    logic signed [COORD_BITS:0] adj_x;
    logic signed [COORD_BITS:0] adj_y;
    logic [COORD_BITS:0]        diff_x;
    logic [COORD_BITS:0]        diff_y;
    coord_t                     mid_x;
    coord_t                     mid_y;
    code_t                      mid_code;
    code_t                      far_code;
    logic                       near_x;
    logic                       near_y;

    // midpoint, halving truncated toward zero
    always_comb
    begin
        sum_x = {op.lo_x[COORD_BITS-1], op.lo_x} + {op.hi_x[COORD_BITS-1], op.hi_x};
        sum_y = {op.lo_y[COORD_BITS-1], op.lo_y} + {op.hi_y[COORD_BITS-1], op.hi_y};
        adj_x = sum_x + {{COORD_BITS{1'b0}}, sum_x[COORD_BITS]};
        adj_y = sum_y + {{COORD_BITS{1'b0}}, sum_y[COORD_BITS]};
        mid_x = adj_x[COORD_BITS:1];
        mid_y = adj_y[COORD_BITS:1];
    end

    assign mid_code = region_code(mid_x, mid_y, win);

    // distance of midpoint to the low end, near when at most one in each axis
    always_comb
    begin
        diff_x = {mid_x[COORD_BITS-1], mid_x} - {op.lo_x[COORD_BITS-1], op.lo_x};
        diff_y = {mid_y[COORD_BITS-1], mid_y} - {op.lo_y[COORD_BITS-1], op.lo_y};
        near_x = (diff_x == '0) || (diff_x == {{COORD_BITS{1'b0}}, 1'b1})
                 || (diff_x == '1);
        near_y = (diff_y == '0) || (diff_y == {{COORD_BITS{1'b0}}, 1'b1})
                 || (diff_y == '1);
    end

    // interval choice and final point selection
    always_comb
    begin
        far_code      = op.toward_end ? op.lo_code : op.hi_code;
        res.mid_x     = mid_x;
        res.mid_y     = mid_y;
        res.mid_code  = mid_code;
        res.stop      = (near_x && near_y) || (op.iter >= iter_t'(SEARCH_LIMIT));
        res.move_hi   = op.toward_end ? ((op.hi_code & mid_code) != CODE_INSIDE)
                                      : ((op.lo_code & mid_code) == CODE_INSIDE);
        if ((mid_code != CODE_INSIDE) && (far_code == CODE_INSIDE))
        begin
            res.res_x    = op.toward_end ? op.lo_x : op.hi_x;
            res.res_y    = op.toward_end ? op.lo_y : op.hi_y;
            res.res_code = CODE_INSIDE;
        end
        else
        begin
            res.res_x    = mid_x;
            res.res_y    = mid_y;
            res.res_code = mid_code;
        end
    end

endmodule

@@ rtl/midpoint_subdivision_line_clipper.sv @@
// a trivial accept or reject goes from the classify state straight to the finish state;
// other segments pass the search state, for the start end and then the end end as needed
// throughput: one segment at a time; each halving is done by the shared step unit
// the next segment is taken once the current result sits in the output register
// reset: asynchronous active low; window returns to 0..4095, no result pending
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clipper
// clips one segment against the configured window by repeated halving
// ----------------------------------------------------------------------------
`include "midpoint_subdivision_line_clipper_assert.svh"

module midpoint_subdivision_line_clipper
    import mslc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mslc_cfg_if.sink    cfg,
    mslc_seg_if.sink    seg,
    mslc_clip_if.source clip
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t    state_reg;
    window_t   win;
    step_in_t  step_op;
    step_out_t step_res;

    coord_t sx_reg, sy_reg, ex_reg, ey_reg;
    code_t  cs_reg, ce_reg;
    coord_t lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg;
    code_t  lo_code_reg, hi_code_reg;
    logic   toward_end_reg;
    iter_t  iter_reg;
    coord_t ax_reg, ay_reg, bx_reg, by_reg;
    code_t  ca_reg, cb_reg;

    logic   out_valid_reg;
    logic   out_visible_reg;
    coord_t out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;
    logic   vis;
    logic   out_free;

    mslc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .win   (win)
    );

    // shared halving unit operands
    always_comb
    begin
        step_op.lo_x       = lo_x_reg;
        step_op.lo_y       = lo_y_reg;
        step_op.hi_x       = hi_x_reg;
        step_op.hi_y       = hi_y_reg;
        step_op.lo_code    = lo_code_reg;
        step_op.hi_code    = hi_code_reg;
        step_op.toward_end = toward_end_reg;
        step_op.iter       = iter_reg;
    end

    mslc_step_unit u_step (
        .win (win),
        .op  (step_op),
        .res (step_res)
    );

    // handshakes
    assign seg.ready          = (state_reg == ST_IDLE);
    assign clip.valid         = out_valid_reg;
    assign clip.visible       = out_visible_reg;
    assign clip.clip_start_x  = out_sx_reg;
    assign clip.clip_start_y  = out_sy_reg;
    assign clip.clip_end_x    = out_ex_reg;
    assign clip.clip_end_y    = out_ey_reg;

    assign vis      = (ca_reg == CODE_INSIDE) && (cb_reg == CODE_INSIDE);
    assign out_free = !out_valid_reg || clip.ready;

    // sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            out_visible_reg <= 1'b0;
            out_sx_reg      <= '0;
            out_sy_reg      <= '0;
            out_ex_reg      <= '0;
            out_ey_reg      <= '0;
            sx_reg          <= '0;
            sy_reg          <= '0;
            ex_reg          <= '0;
            ey_reg          <= '0;
            cs_reg          <= CODE_INSIDE;
            ce_reg          <= CODE_INSIDE;
            lo_x_reg        <= '0;
            lo_y_reg        <= '0;
            hi_x_reg        <= '0;
            hi_y_reg        <= '0;
            lo_code_reg     <= CODE_INSIDE;
            hi_code_reg     <= CODE_INSIDE;
            toward_end_reg  <= 1'b0;
            iter_reg        <= '0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            bx_reg          <= '0;
            by_reg          <= '0;
            ca_reg          <= CODE_INSIDE;
            cb_reg          <= CODE_INSIDE;
        end
        else
        begin
            // result leaves on the output transaction, finish loads its own
            if (out_valid_reg && clip.ready && (state_reg != ST_FINISH))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (seg.valid)
                    begin
                        sx_reg    <= seg.start_x;
                        sy_reg    <= seg.start_y;
                        ex_reg    <= seg.end_x;
                        ey_reg    <= seg.end_y;
                        cs_reg    <= region_code(seg.start_x, seg.start_y, win);
                        ce_reg    <= region_code(seg.end_x, seg.end_y, win);
                        state_reg <= ST_CLASSIFY;
                    end
                end

                ST_CLASSIFY:
                begin
                    ax_reg         <= sx_reg;
                    ay_reg         <= sy_reg;
                    bx_reg         <= ex_reg;
                    by_reg         <= ey_reg;
                    ca_reg         <= cs_reg;
                    cb_reg         <= ce_reg;
                    lo_x_reg       <= sx_reg;
                    lo_y_reg       <= sy_reg;
                    hi_x_reg       <= ex_reg;
                    hi_y_reg       <= ey_reg;
                    lo_code_reg    <= cs_reg;
                    hi_code_reg    <= ce_reg;
                    iter_reg       <= '0;
                    toward_end_reg <= (cs_reg == CODE_INSIDE);
                    // trivial accept or reject skips the search
                    if (((cs_reg | ce_reg) == CODE_INSIDE)
                        || ((cs_reg & ce_reg) != CODE_INSIDE))
                        state_reg <= ST_FINISH;
                    else
                        state_reg <= ST_SEARCH;
                end

                ST_SEARCH:
                begin
                    if (step_res.stop)
                    begin
                        if (!toward_end_reg)
                        begin
                            ax_reg <= step_res.res_x;
                            ay_reg <= step_res.res_y;
                            ca_reg <= step_res.res_code;
                            if (ce_reg != CODE_INSIDE)
                            begin
                                // restart on the whole segment for the end point
                                lo_x_reg       <= sx_reg;
                                lo_y_reg       <= sy_reg;
                                hi_x_reg       <= ex_reg;
                                hi_y_reg       <= ey_reg;
                                lo_code_reg    <= cs_reg;
                                hi_code_reg    <= ce_reg;
                                iter_reg       <= '0;
                                toward_end_reg <= 1'b1;
                            end
                            else
                                state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            bx_reg    <= step_res.res_x;
                            by_reg    <= step_res.res_y;
                            cb_reg    <= step_res.res_code;
                            state_reg <= ST_FINISH;
                        end
                    end
                    else
                    begin
                        if (step_res.move_hi)
                        begin
                            hi_x_reg    <= step_res.mid_x;
                            hi_y_reg    <= step_res.mid_y;
                            hi_code_reg <= step_res.mid_code;
                        end
                        else
                        begin
                            lo_x_reg    <= step_res.mid_x;
                            lo_y_reg    <= step_res.mid_y;
                            lo_code_reg <= step_res.mid_code;
                        end
                        iter_reg <= iter_reg + iter_t'(1);
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_visible_reg <= vis;
                        out_sx_reg      <= vis ? ax_reg : '0;
                        out_sy_reg      <= vis ? ay_reg : '0;
                        out_ex_reg      <= vis ? bx_reg : '0;
                        out_ey_reg      <= vis ? by_reg : '0;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks on the sequencer and result formatting
    `MSLC_ASSERT_SAME(a_hidden_zero, clip.valid && !clip.visible, (clip.clip_start_x == '0) && (clip.clip_start_y == '0) && (clip.clip_end_x == '0) && (clip.clip_end_y == '0), "hidden result with nonzero coordinates")
    `MSLC_ASSERT_SAME(a_iter_bound, state_reg == ST_SEARCH, iter_reg <= iter_t'(SEARCH_LIMIT), "halving count past its bound")
    `MSLC_ASSERT_SAME(a_search_needed, state_reg == ST_SEARCH, ((cs_reg | ce_reg) != CODE_INSIDE) && ((cs_reg & ce_reg) == CODE_INSIDE), "search on a trivial segment")
    `MSLC_ASSERT_SAME(a_end_search, (state_reg == ST_SEARCH) && toward_end_reg, ce_reg != CODE_INSIDE, "end search with end point inside")
    `MSLC_ASSERT_NEXT(a_finish_idle, (state_reg == ST_FINISH) && out_free, (state_reg == ST_IDLE) && clip.valid, "finished result not loaded")

endmodule

@@ dv/mslc_clip_checker.sv @@
// ----------------------------------------------------------------------------
// mslc_clip_checker
// passive monitor of the line clipper channels: tracks window register writes,
// predicts the clip result of every accepted segment and compares each result
// transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------
module mslc_clip_checker
    import mslc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mslc_cfg_if  cfg,
    mslc_seg_if  seg,
    mslc_clip_if clip,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic   visible;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } clip_result_t;

    // shadow copy of the clip window
    longint win_lx;
    longint win_hx;
    longint win_ly;
    longint win_hy;

    clip_result_t expected_clips[$];
    clip_result_t want;
    int           err_cnt = 0;

    assign mismatches = err_cnt;

    // outcode of a point against the shadow window
    function automatic code_t outcode(longint x, longint y);
        code_t c;
        c = CODE_INSIDE;
        if (y < win_ly)
            c = CODE_ABOVE;
        else if (y > win_hy)
            c = CODE_BELOW;
        if (x < win_lx)
            c = c | CODE_LEFT;
        else if (x > win_hx)
            c = c | CODE_RIGHT;
        return c;
    endfunction

    // halving search for the visible point nearest to one end
    function automatic void bisect(input longint hx_i, input longint hy_i,
                                   input longint ex_i, input longint ey_i,
                                   input bit toward_end,
                                   output longint rx, output longint ry);
        longint hx;
        longint hy;
        longint ex;
        longint ey;
        longint mx;
        longint my;
        longint fx;
        longint fy;
        code_t  cm;
        int     it;
        hx = hx_i;
        hy = hy_i;
        ex = ex_i;
        ey = ey_i;
        it = 0;
        forever
        begin
            mx = (hx + ex) / 2;
            my = (hy + ey) / 2;
            if ((mx - hx <= 1 && hx - mx <= 1 && my - hy <= 1 && hy - my <= 1)
                || it >= SEARCH_LIMIT)
                break;
            cm = outcode(mx, my);
            if (!toward_end)
            begin
                if ((outcode(hx, hy) & cm) == CODE_INSIDE)
                begin
                    ex = mx;
                    ey = my;
                end
                else
                begin
                    hx = mx;
                    hy = my;
                end
            end
            else
            begin
                if ((outcode(ex, ey) & cm) != CODE_INSIDE)
                begin
                    ex = mx;
                    ey = my;
                end
                else
                begin
                    hx = mx;
                    hy = my;
                end
            end
            it++;
        end
        // midpoint outside while the inner interval end is inside: take that end
        if (outcode(mx, my) != CODE_INSIDE)
        begin
            fx = toward_end ? hx : ex;
            fy = toward_end ? hy : ey;
            if (outcode(fx, fy) == CODE_INSIDE)
            begin
                mx = fx;
                my = fy;
            end
        end
        rx = mx;
        ry = my;
    endfunction

    // expected clip result of one segment
    function automatic clip_result_t clip_segment(coord_t sx_i, coord_t sy_i,
                                                  coord_t ex_i, coord_t ey_i);
        longint       sx;
        longint       sy;
        longint       ex;
        longint       ey;
        longint       ax;
        longint       ay;
        longint       bx;
        longint       by;
        code_t        cs;
        code_t        ce;
        logic         vis;
        clip_result_t r;
        sx = sx_i;
        sy = sy_i;
        ex = ex_i;
        ey = ey_i;
        ax = sx;
        ay = sy;
        bx = ex;
        by = ey;
        cs = outcode(sx, sy);
        ce = outcode(ex, ey);
        if (cs == CODE_INSIDE && ce == CODE_INSIDE)
            vis = 1'b1;
        else if ((cs & ce) != CODE_INSIDE)
            vis = 1'b0;
        else
        begin
            if (cs != CODE_INSIDE)
                bisect(sx, sy, ex, ey, 1'b0, ax, ay);
            if (ce != CODE_INSIDE)
                bisect(sx, sy, ex, ey, 1'b1, bx, by);
            vis = (outcode(ax, ay) == CODE_INSIDE) && (outcode(bx, by) == CODE_INSIDE);
        end
        r = '0;
        if (vis)
        begin
            r.visible = 1'b1;
            r.start_x = coord_t'(ax);
            r.start_y = coord_t'(ay);
            r.end_x   = coord_t'(bx);
            r.end_y   = coord_t'(by);
        end
        return r;
    endfunction

    // monitor: result check first, then segment prediction, then register update
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_lx = WIN_XMIN_RST;
            win_hx = WIN_XMAX_RST;
            win_ly = WIN_YMIN_RST;
            win_hy = WIN_YMAX_RST;
            expected_clips.delete();
            outstanding <= 0;
        end
        else
        begin
            if (clip.valid && clip.ready)
            begin
                if (expected_clips.size() == 0)
                begin
                    $error("clip transaction with no segment pending");
                    err_cnt++;
                end
                else
                begin
                    want = expected_clips.pop_front();
                    if (clip.visible !== want.visible)
                    begin
                        $error("visible: expected %0d, got %0d", want.visible, clip.visible);
                        err_cnt++;
                    end
                    if (clip.clip_start_x !== want.start_x)
                    begin
                        $error("clip_start_x: expected %0d, got %0d",
                               want.start_x, clip.clip_start_x);
                        err_cnt++;
                    end
                    if (clip.clip_start_y !== want.start_y)
                    begin
                        $error("clip_start_y: expected %0d, got %0d",
                               want.start_y, clip.clip_start_y);
                        err_cnt++;
                    end
                    if (clip.clip_end_x !== want.end_x)
                    begin
                        $error("clip_end_x: expected %0d, got %0d",
                               want.end_x, clip.clip_end_x);
                        err_cnt++;
                    end
                    if (clip.clip_end_y !== want.end_y)
                    begin
                        $error("clip_end_y: expected %0d, got %0d",
                               want.end_y, clip.clip_end_y);
                        err_cnt++;
                    end
                end
            end
            if (seg.valid && seg.ready)
                expected_clips.push_back(clip_segment(seg.start_x, seg.start_y,
                                                      seg.end_x, seg.end_y));
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_WIN_XMIN: win_lx = cfg.data;
                    CFG_WIN_XMAX: win_hx = cfg.data;
                    CFG_WIN_YMIN: win_ly = cfg.data;
                    CFG_WIN_YMAX: win_hy = cfg.data;
                    default: ;
                endcase
            end
            outstanding <= expected_clips.size();
        end
    end

endmodule

@@ dv/midpoint_subdivision_line_clipper_tb.sv @@
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clipper_tb
// drives directed and random segments through the clipper under a series of
// clip windows, with random gaps on the segment side and random stalls on the
// result side; the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module midpoint_subdivision_line_clipper_tb;
    import mslc_pkg::*;

    localparam longint   COORD_MIN       = -(longint'(1) <<< (COORD_BITS - 1));
    localparam longint   COORD_MAX       = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam cfg_idx_t CFG_UNUSED_LO   = cfg_idx_t'(CFG_WIN_YMAX + 1);
    localparam int       CFG_IDX_TOP     = (1 << CFG_IDX_BITS) - 1;
    localparam int       PHASE_ITEMS     = 188;
    localparam int       DRAIN_CYCLES    = 100;
    localparam int       WATCHDOG_LIMIT  = 4000;

    typedef enum int {
        WIN_DEFAULT,
        WIN_RANDOM,
        WIN_FULL,
        WIN_NARROW,
        WIN_HIGH,
        WIN_LOW,
        WIN_INVERTED,
        WIN_MIXED
    } win_mode_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   idle_cycles = 0;
    bit   seg_burst   = 1'b0;
    bit   clip_burst  = 1'b0;

    // window as currently programmed, used to aim the stimulus
    longint cur_lx = WIN_XMIN_RST;
    longint cur_hx = WIN_XMAX_RST;
    longint cur_ly = WIN_YMIN_RST;
    longint cur_hy = WIN_YMAX_RST;

    mslc_cfg_if  cfg_ch();
    mslc_seg_if  seg_ch();
    mslc_clip_if clip_ch();

    midpoint_subdivision_line_clipper uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .seg   (seg_ch),
        .clip  (clip_ch)
    );

    mslc_clip_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .seg         (seg_ch),
        .clip        (clip_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
        clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((seg_ch.valid && seg_ch.ready) || (clip_ch.valid && clip_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("midpoint_subdivision_line_clipper test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall before every transaction, bursts without stalls
    initial
    begin
        int stall;
        clip_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(63) == 0)
                clip_burst = !clip_burst;
            stall = clip_burst ? 0 : $urandom_range(7);
            if (stall > 0)
            begin
                clip_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            clip_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(clip_ch.valid && clip_ch.ready));
        end
    end

    // one segment transaction after a random gap outside bursts; valid stays high afterwards
    task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int gap;
        if ($urandom_range(63) == 0)
            seg_burst = !seg_burst;
        gap = seg_burst ? 0 : $urandom_range(7);
        if (gap > 0)
        begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= sx;
        seg_ch.start_y <= sy;
        seg_ch.end_x   <= ex;
        seg_ch.end_y   <= ey;
        do
            @(posedge clk);
        while (!seg_ch.ready);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_idle();
        seg_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write transaction; valid is lowered by the caller
    task automatic write_reg(cfg_idx_t idx, coord_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // program all four window edges plus a write to an unused index
    task automatic set_window(longint lx, longint hx, longint ly, longint hy);
        write_reg(CFG_WIN_XMIN, coord_t'(lx));
        write_reg(CFG_WIN_XMAX, coord_t'(hx));
        write_reg(CFG_WIN_YMIN, coord_t'(ly));
        write_reg(CFG_WIN_YMAX, coord_t'(hy));
        write_reg(cfg_idx_t'($urandom_range(int'(CFG_UNUSED_LO), CFG_IDX_TOP)),
                  coord_t'($urandom));
        cfg_ch.valid <= 1'b0;
        cur_lx = lx;
        cur_hx = hx;
        cur_ly = ly;
        cur_hy = hy;
    endtask

    // edge pair of one window axis for a given mode
    task automatic axis_range(win_mode_t mode, output longint lo, output longint hi);
        case (mode)
            WIN_DEFAULT:
            begin
                lo = WIN_XMIN_RST;
                hi = WIN_XMAX_RST;
            end
            WIN_FULL:
            begin
                lo = COORD_MIN;
                hi = COORD_MAX;
            end
            WIN_NARROW:
            begin
                lo = longint'(coord_t'($urandom));
                hi = lo + $urandom_range(3);
            end
            WIN_HIGH:
            begin
                hi = COORD_MAX;
                lo = COORD_MAX - $urandom_range(5000);
            end
            WIN_LOW:
            begin
                lo = COORD_MIN;
                hi = COORD_MIN + $urandom_range(5000);
            end
            WIN_INVERTED:
            begin
                lo = COORD_MIN + 3001 + $urandom_range(60000);
                hi = lo - 1 - $urandom_range(3000);
            end
            default:
            begin
                lo = longint'(coord_t'($urandom));
                hi = lo + $urandom_range(20000);
            end
        endcase
        if (lo > COORD_MAX)
            lo = COORD_MAX;
        if (hi > COORD_MAX)
            hi = COORD_MAX;
    endtask

    // coordinate around a window axis, often right on an edge
    function automatic coord_t near_coord(longint lo, longint hi);
        longint a;
        longint b;
        longint span;
        longint v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = (b - a) + 16;
        case ($urandom_range(15))
            0: v = a - 1;
            1: v = a;
            2: v = b;
            3: v = b + 1;
            default: v = a - span + $urandom_range(int'((b - a) + 2 * span));
        endcase
        if (v < COORD_MIN)
            v = COORD_MIN;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    // coordinate between the edges of an axis, both edges included
    function automatic coord_t pick_between(longint lo, longint hi);
        longint a;
        longint b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        return coord_t'(a + $urandom_range(int'(b - a)));
    endfunction

    // random segment: mostly aimed at the window, some full range
    task automatic random_segment();
        int     pick;
        coord_t px;
        coord_t py;
        coord_t qx;
        coord_t qy;
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            px = near_coord(cur_lx, cur_hx);
            py = near_coord(cur_ly, cur_hy);
            qx = near_coord(cur_lx, cur_hx);
            qy = near_coord(cur_ly, cur_hy);
        end
        else if (pick < 8)
        begin
            px = pick_between(cur_lx, cur_hx);
            py = pick_between(cur_ly, cur_hy);
            if (pick == 7)
            begin
                qx = coord_t'($urandom);
                qy = coord_t'($urandom);
            end
            else
            begin
                qx = near_coord(cur_lx, cur_hx);
                qy = near_coord(cur_ly, cur_hy);
            end
        end
        else
        begin
            px = coord_t'($urandom);
            py = coord_t'($urandom);
            qx = coord_t'($urandom);
            qy = coord_t'($urandom);
        end
        // inside end on either side
        if ($urandom_range(1))
            send_segment(px, py, qx, qy);
        else
            send_segment(qx, qy, px, py);
    endtask

    // stimulus and verdict
    initial
    begin
        longint    lx;
        longint    hx;
        longint    ly;
        longint    hy;
        win_mode_t mode;
        seg_ch.valid   <= 1'b0;
        seg_ch.start_x <= '0;
        seg_ch.start_y <= '0;
        seg_ch.end_x   <= '0;
        seg_ch.end_y   <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_WIN_XMIN;
        cfg_ch.data    <= '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset window
        send_segment(coord_t'(10), coord_t'(20), coord_t'(4000), coord_t'(4090));
        send_segment(coord_t'(-100), coord_t'(10), coord_t'(-5), coord_t'(3000));
        send_segment(coord_t'(-1000), coord_t'(2000), coord_t'(2000), coord_t'(2000));
        send_segment(coord_t'(100), coord_t'(100), coord_t'(9000), coord_t'(500));
        send_segment(coord_t'(-5000), coord_t'(-5000), coord_t'(9000), coord_t'(9000));
        // no shared bit but the line passes the corner outside
        send_segment(coord_t'(-3000), coord_t'(1000), coord_t'(1000), coord_t'(-3000));
        send_segment(coord_t'(COORD_MIN), coord_t'(COORD_MIN),
                     coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        send_segment(coord_t'(COORD_MAX), coord_t'(COORD_MIN),
                     coord_t'(COORD_MIN), coord_t'(COORD_MAX));
        send_segment(coord_t'(COORD_MAX), coord_t'(COORD_MIN),
                     coord_t'(COORD_MIN), coord_t'(COORD_MIN));
        send_segment(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0));
        send_segment(coord_t'(4095), coord_t'(4095), coord_t'(4095), coord_t'(4095));
        send_segment(coord_t'(5000), coord_t'(5000), coord_t'(5000), coord_t'(5000));
        send_segment(coord_t'(-1), coord_t'(0), coord_t'(0), coord_t'(0));
        send_segment(coord_t'(4096), coord_t'(4095), coord_t'(4095), coord_t'(4095));
        send_segment(coord_t'(2000), coord_t'(COORD_MIN), coord_t'(2000), coord_t'(COORD_MAX));
        send_segment(coord_t'(COORD_MIN), coord_t'(2000), coord_t'(COORD_MAX), coord_t'(2000));
        send_segment(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(-1), coord_t'(-1));

        // directed, full range window
        wait_idle();
        set_window(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send_segment(coord_t'(COORD_MIN), coord_t'(COORD_MAX),
                     coord_t'(COORD_MAX), coord_t'(COORD_MIN));
        send_segment(coord_t'(COORD_MAX), coord_t'(COORD_MAX),
                     coord_t'(COORD_MIN), coord_t'(COORD_MIN));

        // directed, single point window
        wait_idle();
        set_window(0, 0, 0, 0);
        send_segment(coord_t'(-5), coord_t'(-5), coord_t'(5), coord_t'(5));
        send_segment(coord_t'(-5), coord_t'(5), coord_t'(5), coord_t'(-5));
        send_segment(coord_t'(0), coord_t'(0), coord_t'(COORD_MAX), coord_t'(0));

        // directed, window with xmin above xmax
        wait_idle();
        set_window(100, -100, 0, 4095);
        send_segment(coord_t'(-200), coord_t'(50), coord_t'(200), coord_t'(50));
        send_segment(coord_t'(0), coord_t'(50), coord_t'(0), coord_t'(60));
        send_segment(coord_t'(COORD_MIN), coord_t'(COORD_MIN),
                     coord_t'(COORD_MAX), coord_t'(COORD_MAX));

        // random phases, one window setting each
        for (int ph = 0; ph < 8; ph++)
        begin
            mode = win_mode_t'(ph);
            if (mode == WIN_MIXED)
            begin
                axis_range(WIN_RANDOM, lx, hx);
                axis_range(WIN_NARROW, ly, hy);
            end
            else
            begin
                axis_range(mode, lx, hx);
                if (mode == WIN_INVERTED && $urandom_range(1))
                    axis_range(WIN_RANDOM, ly, hy);
                else
                    axis_range(mode, ly, hy);
            end
            wait_idle();
            set_window(lx, hx, ly, hy);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_segment();
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("midpoint_subdivision_line_clipper test passed");
        else
            $display("midpoint_subdivision_line_clipper test failed");
        $finish;
    end

endmodule
